// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

// Checked only while out of reset.
`define ASSERT_RUN(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`define ASSERT_RUN(lbl, clk, rst_n, prop, msg)

`endif

`endif

// File: rtl/calu_pkg.sv
// ---------------------------------------------------------------------------
// calu_pkg
// Shared types, command codes and constants of the 8-bit flag ALU.
// ---------------------------------------------------------------------------
`default_nettype none

package calu_pkg;

    typedef enum logic [4:0] {
        CMD_ADD    = 5'd0,
        CMD_ADC    = 5'd1,
        CMD_SUB    = 5'd2,
        CMD_SBC    = 5'd3,
        CMD_AND    = 5'd4,
        CMD_OR     = 5'd5,
        CMD_XOR    = 5'd6,
        CMD_CP     = 5'd7,
        CMD_INC    = 5'd8,
        CMD_DEC    = 5'd9,
        CMD_ADD16  = 5'd10,
        CMD_ADDSP  = 5'd11,
        CMD_LDHLSP = 5'd12,
        CMD_RLC    = 5'd13,
        CMD_RRC    = 5'd14,
        CMD_RL     = 5'd15,
        CMD_RR     = 5'd16,
        CMD_SLA    = 5'd17,
        CMD_SRA    = 5'd18,
        CMD_SWAP   = 5'd19,
        CMD_SRL    = 5'd20,
        CMD_BIT    = 5'd21,
        CMD_RLCA   = 5'd22,
        CMD_RRCA   = 5'd23,
        CMD_RLA    = 5'd24,
        CMD_RRA    = 5'd25,
        CMD_DAA    = 5'd26,
        CMD_LOAD   = 5'd27
    } cmd_e;

    typedef enum logic [2:0] {
        SH_RLC  = 3'd0,
        SH_RRC  = 3'd1,
        SH_RL   = 3'd2,
        SH_RR   = 3'd3,
        SH_SLA  = 3'd4,
        SH_SRA  = 3'd5,
        SH_SWAP = 3'd6,
        SH_SRL  = 3'd7
    } shift_kind_e;

    // decimal adjust limits and corrections
    localparam logic [3:0] DAA_LOW_LIMIT  = 4'h9;
    localparam logic [8:0] DAA_HIGH_LIMIT = 9'h09F;
    localparam logic [8:0] DAA_LOW_ADJ    = 9'h006;
    localparam logic [8:0] DAA_HIGH_ADJ   = 9'h060;

    typedef struct packed {
        logic [4:0]  cmd;
        logic [7:0]  operand;
        logic [2:0]  bit_index;
        logic [15:0] word_operand;
        logic [15:0] word_addend;
        logic [7:0]  offset;
        logic [3:0]  flags_in;
    } item_t;

    // architectural state: accumulator and Z, N, H, C
    typedef struct packed {
        logic [7:0] acc;
        logic       z;
        logic       n;
        logic       h;
        logic       c;
    } state_t;

endpackage

`default_nettype wire

// File: rtl/calu_req_if.sv
// ---------------------------------------------------------------------------
// calu_req_if
// Request channel of the flag ALU: valid/ready plus one command.
// ---------------------------------------------------------------------------
`default_nettype none

interface calu_req_if;
    logic              valid;
    logic              ready;
    logic [4:0]        cmd;
    logic [7:0]        operand;
    logic [2:0]        bit_index;
    logic [15:0]       word_operand;
    logic [15:0]       word_addend;
    logic signed [7:0] offset;
    logic [3:0]        flags_in;

    modport source (
        output valid, cmd, operand, bit_index, word_operand, word_addend, offset, flags_in,
        input  ready
    );

    modport sink (
        input  valid, cmd, operand, bit_index, word_operand, word_addend, offset, flags_in,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/calu_rsp_if.sv
// ---------------------------------------------------------------------------
// calu_rsp_if
// Response channel of the flag ALU: valid/ready plus result and flags.
// ---------------------------------------------------------------------------
`default_nettype none

interface calu_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] result;
    logic [7:0]  accumulator;
    logic        zero_flag;
    logic        subtract_flag;
    logic        half_carry_flag;
    logic        carry_flag;

    modport source (
        output valid, result, accumulator, zero_flag, subtract_flag,
               half_carry_flag, carry_flag,
        input  ready
    );

    modport sink (
        input  valid, result, accumulator, zero_flag, subtract_flag,
               half_carry_flag, carry_flag,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/calu_core.sv
// ---------------------------------------------------------------------------
// calu_core
// Combinational datapath: one command against the current state.
// ---------------------------------------------------------------------------
`default_nettype none

module calu_core (
    input  calu_pkg::item_t  item,
    input  calu_pkg::state_t state,
    output logic [15:0]      result,
    output calu_pkg::state_t state_next
);

    // returns {carry_out, byte}
    function automatic logic [8:0] shift8(
        input logic [2:0] kind,
        input logic [7:0] v,
        input logic       cf
    );
        logic [8:0] r;
        case (kind)
            calu_pkg::SH_RLC:  r = {v[7], v[6:0], v[7]};
            calu_pkg::SH_RRC:  r = {v[0], v[0], v[7:1]};
            calu_pkg::SH_RL:   r = {v[7], v[6:0], cf};
            calu_pkg::SH_RR:   r = {v[0], cf, v[7:1]};
            calu_pkg::SH_SLA:  r = {v[7], v[6:0], 1'b0};
            calu_pkg::SH_SRA:  r = {v[0], v[7], v[7:1]};
            calu_pkg::SH_SWAP: r = {1'b0, v[3:0], v[7:4]};
            default:           r = {v[0], 1'b0, v[7:1]};
        endcase
        return r;
    endfunction

    logic [7:0]  a;
    logic [7:0]  v;
    logic        cin;
    logic [8:0]  sum9;
    logic [4:0]  sum5;
    logic [8:0]  dif9;
    logic [4:0]  dif5;
    logic [16:0] wsum17;
    logic [12:0] wsum13;
    logic [15:0] off_ext;
    logic [8:0]  sp9;
    logic [4:0]  sp5;
    logic [7:0]  inc8;
    logic [7:0]  dec8;
    logic [8:0]  sh_v;
    logic [8:0]  sh_a;
    logic [8:0]  daa_t;

    assign a   = state.acc;
    assign v   = item.operand;
    assign cin = ((item.cmd == calu_pkg::CMD_ADC) || (item.cmd == calu_pkg::CMD_SBC))
                 ? state.c : 1'b0;

    assign sum9 = {1'b0, a} + {1'b0, v} + {8'd0, cin};
    assign sum5 = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, cin};
    assign dif9 = {1'b0, a} - {1'b0, v} - {8'd0, cin};        // bit 8 = borrow
    assign dif5 = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, cin};

    assign wsum17  = {1'b0, item.word_operand} + {1'b0, item.word_addend};
    assign wsum13  = {1'b0, item.word_operand[11:0]} + {1'b0, item.word_addend[11:0]};
    assign off_ext = {{8{item.offset[7]}}, item.offset};
    // SP flags come from unsigned carries of the low byte
    assign sp9     = {1'b0, item.word_operand[7:0]} + {1'b0, item.offset};
    assign sp5     = {1'b0, item.word_operand[3:0]} + {1'b0, item.offset[3:0]};

    assign inc8 = v + 8'd1;
    assign dec8 = v - 8'd1;

    assign sh_v = shift8(3'(item.cmd - calu_pkg::CMD_RLC), v, state.c);
    assign sh_a = shift8(3'(item.cmd - calu_pkg::CMD_RLCA), a, state.c);

    always_comb
    begin
        daa_t = {1'b0, a};
        if (!state.n)
        begin
            if (state.h || (a[3:0] > calu_pkg::DAA_LOW_LIMIT))
                daa_t = daa_t + calu_pkg::DAA_LOW_ADJ;
            if (state.c || (daa_t > calu_pkg::DAA_HIGH_LIMIT))
                daa_t = daa_t + calu_pkg::DAA_HIGH_ADJ;
        end
        else
        begin
            if (state.h)
                daa_t = daa_t - calu_pkg::DAA_LOW_ADJ;
            if (state.c)
                daa_t = daa_t - calu_pkg::DAA_HIGH_ADJ;
        end
    end

    always_comb
    begin
        state_next = state;
        result     = {8'd0, a};
        case (item.cmd)
            calu_pkg::CMD_ADD, calu_pkg::CMD_ADC:
            begin
                state_next.acc = sum9[7:0];
                state_next.z   = (sum9[7:0] == 8'd0);
                state_next.n   = 1'b0;
                state_next.h   = sum5[4];
                state_next.c   = sum9[8];
                result         = {8'd0, sum9[7:0]};
            end
            calu_pkg::CMD_SUB, calu_pkg::CMD_SBC, calu_pkg::CMD_CP:
            begin
                if (item.cmd != calu_pkg::CMD_CP)
                    state_next.acc = dif9[7:0];
                state_next.z = (dif9[7:0] == 8'd0);
                state_next.n = 1'b1;
                state_next.h = dif5[4];
                state_next.c = dif9[8];
                result       = (item.cmd != calu_pkg::CMD_CP) ? {8'd0, dif9[7:0]} : {8'd0, a};
            end
            calu_pkg::CMD_AND:
            begin
                state_next.acc = a & v;
                state_next.z   = ((a & v) == 8'd0);
                state_next.n   = 1'b0;
                state_next.h   = 1'b1;
                state_next.c   = 1'b0;
                result         = {8'd0, a & v};
            end
            calu_pkg::CMD_OR:
            begin
                state_next.acc = a | v;
                state_next.z   = ((a | v) == 8'd0);
                state_next.n   = 1'b0;
                state_next.h   = 1'b0;
                state_next.c   = 1'b0;
                result         = {8'd0, a | v};
            end
            calu_pkg::CMD_XOR:
            begin
                state_next.acc = a ^ v;
                state_next.z   = ((a ^ v) == 8'd0);
                state_next.n   = 1'b0;
                state_next.h   = 1'b0;
                state_next.c   = 1'b0;
                result         = {8'd0, a ^ v};
            end
            calu_pkg::CMD_INC:
            begin
                state_next.z = (inc8 == 8'd0);
                state_next.n = 1'b0;
                state_next.h = (v[3:0] == 4'hF);
                result       = {8'd0, inc8};
            end
            calu_pkg::CMD_DEC:
            begin
                state_next.z = (dec8 == 8'd0);
                state_next.n = 1'b1;
                state_next.h = (v[3:0] == 4'h0);
                result       = {8'd0, dec8};
            end
            calu_pkg::CMD_ADD16:
            begin
                state_next.n = 1'b0;
                state_next.h = wsum13[12];
                state_next.c = wsum17[16];
                result       = wsum17[15:0];
            end
            calu_pkg::CMD_ADDSP, calu_pkg::CMD_LDHLSP:
            begin
                state_next.z = 1'b0;
                state_next.n = 1'b0;
                state_next.h = sp5[4];
                state_next.c = sp9[8];
                result       = item.word_operand + off_ext;
            end
            calu_pkg::CMD_RLC, calu_pkg::CMD_RRC, calu_pkg::CMD_RL, calu_pkg::CMD_RR,
            calu_pkg::CMD_SLA, calu_pkg::CMD_SRA, calu_pkg::CMD_SWAP, calu_pkg::CMD_SRL:
            begin
                state_next.z = (sh_v[7:0] == 8'd0);
                state_next.n = 1'b0;
                state_next.h = 1'b0;
                state_next.c = sh_v[8];
                result       = {8'd0, sh_v[7:0]};
            end
            calu_pkg::CMD_BIT:
            begin
                state_next.z = !v[item.bit_index];
                state_next.n = 1'b0;
                state_next.h = 1'b1;
                result       = 16'd0;
            end
            calu_pkg::CMD_RLCA, calu_pkg::CMD_RRCA, calu_pkg::CMD_RLA, calu_pkg::CMD_RRA:
            begin
                state_next.acc = sh_a[7:0];
                state_next.z   = 1'b0;
                state_next.n   = 1'b0;
                state_next.h   = 1'b0;
                state_next.c   = sh_a[8];
                result         = {8'd0, sh_a[7:0]};
            end
            calu_pkg::CMD_DAA:
            begin
                state_next.acc = daa_t[7:0];
                state_next.z   = (daa_t[7:0] == 8'd0);
                state_next.h   = 1'b0;
                state_next.c   = state.c | (!state.n & daa_t[8]);
                result         = {8'd0, daa_t[7:0]};
            end
            calu_pkg::CMD_LOAD:
            begin
                state_next.acc = v;
                state_next.z   = item.flags_in[3];
                state_next.n   = item.flags_in[2];
                state_next.h   = item.flags_in[1];
                state_next.c   = item.flags_in[0];
                result         = {8'd0, v};
            end
            default:
            begin
                state_next = state;
                result     = {8'd0, a};
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/cpu_alu_with_flags.sv
// ---------------------------------------------------------------------------
// cpu_alu_with_flags
// 8-bit ALU with accumulator and Z/N/H/C flags, one command per request.
// ---------------------------------------------------------------------------
//
//   channel | dir | payload
//   --------+-----+-----------------------------------------------------------
//   req     | in  | cmd, operand, bit_index, word_operand, word_addend,
//           |     | offset, flags_in
//   rsp     | out | result, accumulator, zero_flag, subtract_flag,
//           |     | half_carry_flag, carry_flag
//
// Throughput: one request per clock while rsp is ready. Each request waits in
// the input stage register, where calu_core evaluates it against the current
// accumulator and flags; the response register and the state registers load
// together when the request advances, so the following request already sees
// the new state. The response is registered behind the input stage.
// Reset (rst_n, async, low) clears the accumulator, the flags and both valid
// bits. A stalled rsp holds the response and the input stage; req.ready
// drops only when both the stage and the response register are full.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cpu_alu_with_flags (
    input  logic              clk,
    input  logic              rst_n,
    calu_req_if.sink          req,
    calu_rsp_if.source        rsp
);

    // input stage
    logic             stage_valid_reg;
    calu_pkg::item_t  stage_reg;

    // response register
    logic             rsp_valid_reg;
    logic [15:0]      result_reg;

    // architectural state
    calu_pkg::state_t state_reg;
    calu_pkg::state_t state_next;
    logic [15:0]      result_next;

    logic             advance;

    // stage moves into the response register when that slot is free or draining
    assign advance   = stage_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !stage_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (req.ready)
            stage_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            stage_reg.cmd          <= req.cmd;
            stage_reg.operand      <= req.operand;
            stage_reg.bit_index    <= req.bit_index;
            stage_reg.word_operand <= req.word_operand;
            stage_reg.word_addend  <= req.word_addend;
            stage_reg.offset       <= req.offset;
            stage_reg.flags_in     <= req.flags_in;
        end
    end

    calu_core u_core (
        .item       (stage_reg),
        .state      (state_reg),
        .result     (result_next),
        .state_next (state_next)
    );

    // state commits together with the response it belongs to
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    // accumulator and flags shown are the committed state
    assign rsp.valid           = rsp_valid_reg;
    assign rsp.result          = result_reg;
    assign rsp.accumulator     = state_reg.acc;
    assign rsp.zero_flag       = state_reg.z;
    assign rsp.subtract_flag   = state_reg.n;
    assign rsp.half_carry_flag = state_reg.h;
    assign rsp.carry_flag      = state_reg.c;

    // ---------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------
    `ASSERT_ALWAYS(a_ready_only_when_full, clk, !req.ready |-> (stage_valid_reg && rsp_valid_reg && !rsp.ready), "req stalled without a full pipe")
    `ASSERT_RUN(a_stage_held, clk, rst_n, (stage_valid_reg && !advance) |=> (stage_valid_reg && $stable(stage_reg)), "pending request lost or changed")
    `ASSERT_RUN(a_state_only_on_advance, clk, rst_n, !advance |=> $stable(state_reg), "state changed without a response")
    `ASSERT_RUN(a_advance_gives_rsp, clk, rst_n, advance |=> rsp_valid_reg, "committed request produced no response")

endmodule

`default_nettype wire
